// ----- sv/bdg_pkg.sv -----
// ----------------------------------------------------------------------------
// bdg_pkg
// Shared types and constants for the ballistic deposition grid: item
// formats, register indexes, grid geometry and controller/datapath links.
// ----------------------------------------------------------------------------
package bdg_pkg;

  // Grid geometry
  localparam int GRID_COLS  = 256;
  localparam int GRID_ROWS  = 256;
  localparam int GRID_DEPTH = GRID_ROWS * GRID_COLS;
  localparam int ROW_W      = $clog2(GRID_ROWS);
  localparam int COL_W      = $clog2(GRID_COLS);
  localparam int ADDR_W     = $clog2(GRID_DEPTH);

  // Register widths and reset values
  localparam int STEP_W        = 26;
  localparam int SPREAD_W      = 17;
  localparam int CFG_W         = 26;
  localparam int STEP_RESET    = 65536;
  localparam int SPREAD_RESET  = 0;
  localparam int ONE_Q16       = 65536;

  // Arithmetic widths
  localparam int FACTOR_W = 33;  // Q1.32, up to exactly 1.0
  localparam int MUL_W    = 43;  // step x 17-bit slice of the factor
  localparam int ACC_W    = 59;
  localparam int SIZE_W   = 27;

  typedef enum logic [1:0] {
    OP_DEPOSIT = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2
  } opcode_t;

  typedef enum logic [0:0] {
    CFG_STEP_HEIGHT   = 1'b0,
    CFG_HEIGHT_SPREAD = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         row;
    logic [7:0]         col;
    logic [15:0]        random_fraction;
    logic signed [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] cell_value;
    logic               saturated;
  } rsp_t;

  // Grid memory address source
  typedef enum logic [2:0] {
    ADDR_CENTER = 3'd0,
    ADDR_UP     = 3'd1,
    ADDR_DN     = 3'd2,
    ADDR_LF     = 3'd3,
    ADDR_RT     = 3'd4,
    ADDR_CLEAR  = 3'd5
  } addr_sel_t;

  // Grid memory write data source
  typedef enum logic [1:0] {
    WSEL_ZERO  = 2'd0,
    WSEL_VALUE = 2'd1,
    WSEL_DEP   = 2'd2
  } wsel_t;

  // Which neighbor the captured read data belongs to
  typedef enum logic [1:0] {
    NBR_UP = 2'd0,
    NBR_DN = 2'd1,
    NBR_LF = 2'd2,
    NBR_RT = 2'd3
  } nbr_t;

  // Result register source
  typedef enum logic [1:0] {
    RES_HOLD  = 2'd0,
    RES_RDATA = 2'd1,
    RES_WVAL  = 2'd2,
    RES_DEP   = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic      load_req;
    logic      mem_rd;
    logic      mem_we;
    addr_sel_t addr_sel;
    wsel_t     wdata_sel;
    logic      clr_step;
    logic      cap_center;
    logic      cap_nbr;
    nbr_t      nbr_sel;
    logic      calc_su;
    logic      calc_factor;
    logic      mul_lo;
    logic      mul_hi;
    logic      calc_sum;
    res_sel_t  res_sel;
    logic      load_rsp;
  } bdg_cmd_t;

  typedef struct packed {
    logic req_deposit;
    logic req_write;
    logic clr_last;
  } bdg_status_t;

endpackage

// ----- sv/bdg_datapath.sv -----
// ----------------------------------------------------------------------------
// bdg_datapath
// Height grid memory, configuration registers, particle size arithmetic,
// neighbor maximum and the result register.
// ----------------------------------------------------------------------------
module bdg_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  bdg_pkg::req_t              req,
  output bdg_pkg::rsp_t              rsp,
  input  logic                       cfg_we,
  input  bdg_pkg::cfg_idx_t          cfg_index,
  input  logic [bdg_pkg::CFG_W-1:0]  cfg_data,
  input  bdg_pkg::bdg_cmd_t          cmd,
  output bdg_pkg::bdg_status_t       status
);
  import bdg_pkg::*;

  // Configuration
  logic [STEP_W-1:0]   step_height;
  logic [SPREAD_W-1:0] height_spread;

  // Latched item
  logic [ADDR_W-1:0]   addr;
  logic                has_up, has_dn, has_lf, has_rt;
  logic [15:0]         frac;
  logic signed [31:0]  wval;

  // Address decode of the incoming item
  logic [ROW_W-1:0]    row_cl;
  logic [COL_W-1:0]    col_cl;
  logic [ADDR_W-1:0]   addr_in;

  // Memory
  logic [31:0]         grid_mem [GRID_DEPTH];
  logic [ADDR_W-1:0]   mem_addr;
  logic [31:0]         mem_wdata;
  logic [31:0]         rdata;
  logic [ADDR_W-1:0]   clr_addr;

  // Arithmetic
  logic [SPREAD_W-1:0] spread_cl;
  logic [SPREAD_W-1:0] one_minus;
  logic [FACTOR_W-1:0] su;
  logic [FACTOR_W-1:0] factor;
  logic [SPREAD_W-1:0] mul_b;
  logic [MUL_W-1:0]    mul_p;
  logic [ACC_W-1:0]    acc;
  logic [SIZE_W-1:0]   size;
  logic [32:0]         sum_ext;
  logic signed [31:0]  center;
  logic signed [31:0]  nbr_max;
  logic signed [31:0]  h_clip;
  logic                h_sat;
  logic signed [31:0]  dep_val;
  logic                nbr_ok;

  logic signed [31:0]  res_value;
  logic                res_sat;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_height   <= STEP_W'(STEP_RESET);
      height_spread <= SPREAD_W'(SPREAD_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_HEIGHT:   step_height   <= cfg_data[STEP_W-1:0];
        CFG_HEIGHT_SPREAD: height_spread <= cfg_data[SPREAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the coordinates to the grid and form the linear address
  always_comb begin
    if (int'(req.row) > GRID_ROWS - 1) row_cl = ROW_W'(GRID_ROWS - 1);
    else                               row_cl = ROW_W'(req.row);
    if (int'(req.col) > GRID_COLS - 1) col_cl = COL_W'(GRID_COLS - 1);
    else                               col_cl = COL_W'(req.col);
    addr_in = ADDR_W'(ADDR_W'(row_cl) * ADDR_W'(GRID_COLS)) + ADDR_W'(col_cl);
  end

  assign status.req_deposit = (req.opcode == OP_DEPOSIT);
  assign status.req_write   = (req.opcode == OP_WRITE);
  assign status.clr_last    = (clr_addr == ADDR_W'(GRID_DEPTH - 1));

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      addr   <= addr_in;
      has_up <= (row_cl != ROW_W'(0));
      has_dn <= (row_cl != ROW_W'(GRID_ROWS - 1));
      has_lf <= (col_cl != COL_W'(0));
      has_rt <= (col_cl != COL_W'(GRID_COLS - 1));
      frac   <= req.random_fraction;
      wval   <= req.write_value;
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst)               clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= clr_addr + ADDR_W'(1);
  end

  // Memory address and write data
  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_CENTER: mem_addr = addr;
      ADDR_UP:     mem_addr = addr - ADDR_W'(GRID_COLS);
      ADDR_DN:     mem_addr = addr + ADDR_W'(GRID_COLS);
      ADDR_LF:     mem_addr = addr - ADDR_W'(1);
      ADDR_RT:     mem_addr = addr + ADDR_W'(1);
      ADDR_CLEAR:  mem_addr = clr_addr;
      default:     mem_addr = addr;
    endcase
    unique case (cmd.wdata_sel)
      WSEL_ZERO:  mem_wdata = '0;
      WSEL_VALUE: mem_wdata = wval;
      WSEL_DEP:   mem_wdata = dep_val;
      default:    mem_wdata = '0;
    endcase
  end

  // Single-port grid memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_we)      grid_mem[mem_addr] <= mem_wdata;
    else if (cmd.mem_rd) rdata <= grid_mem[mem_addr];
  end

  // Particle size: factor = 1 - s + s*u, size = (step * factor) >> 32
  assign spread_cl = (height_spread > SPREAD_W'(ONE_Q16)) ? SPREAD_W'(ONE_Q16)
                                                          : height_spread;
  assign one_minus = SPREAD_W'(ONE_Q16) - spread_cl;
  assign mul_b     = cmd.mul_hi ? factor[FACTOR_W-1:16] : {1'b0, factor[15:0]};
  assign mul_p     = MUL_W'(step_height) * MUL_W'(mul_b);
  assign size      = acc[ACC_W-1:32];

  always_ff @(posedge clk) begin
    if (cmd.calc_su)     su     <= FACTOR_W'(spread_cl) * FACTOR_W'(frac);
    if (cmd.calc_factor) factor <= {one_minus, 16'b0} + su;
    if (cmd.mul_lo)      acc    <= ACC_W'(mul_p);
    else if (cmd.mul_hi) acc    <= acc + {mul_p, 16'b0};
  end

  // Saturating sum of old height and particle size
  assign sum_ext = {center[31], center} + 33'(size);

  // Neighbor gate for the word just read
  always_comb begin
    unique case (cmd.nbr_sel)
      NBR_UP:  nbr_ok = has_up;
      NBR_DN:  nbr_ok = has_dn;
      NBR_LF:  nbr_ok = has_lf;
      NBR_RT:  nbr_ok = has_rt;
      default: nbr_ok = 1'b0;
    endcase
  end

  // Center and running neighbor maximum; a missing neighbor is skipped
  // since the grown height never falls below the old one.
  always_ff @(posedge clk) begin
    if (cmd.cap_center) begin
      center  <= rdata;
      nbr_max <= rdata;
    end else if (cmd.cap_nbr && nbr_ok && ($signed(rdata) > nbr_max)) begin
      nbr_max <= rdata;
    end
    if (cmd.calc_sum) begin
      if (!sum_ext[32] && sum_ext[31]) begin
        h_clip <= 32'sh7FFF_FFFF;
        h_sat  <= 1'b1;
      end else begin
        h_clip <= sum_ext[31:0];
        h_sat  <= 1'b0;
      end
    end
  end

  assign dep_val = (nbr_max > h_clip) ? nbr_max : h_clip;

  // Result register and output register
  always_ff @(posedge clk) begin
    unique case (cmd.res_sel)
      RES_HOLD: ;
      RES_RDATA: begin
        res_value <= rdata;
        res_sat   <= 1'b0;
      end
      RES_WVAL: begin
        res_value <= wval;
        res_sat   <= 1'b0;
      end
      RES_DEP: begin
        res_value <= dep_val;
        res_sat   <= h_sat;
      end
      default: ;
    endcase
    if (cmd.load_rsp) begin
      rsp.cell_value <= res_value;
      rsp.saturated  <= res_sat;
    end
  end

endmodule

// ----- sv/bdg_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdg_ctrl
// Sequencer for the grid: clearing pass after reset, the read schedule of
// a deposit, cell write and read, and the handshakes on both channels.
// ----------------------------------------------------------------------------
module bdg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  bdg_pkg::bdg_status_t status,
  output bdg_pkg::bdg_cmd_t    cmd
);
  import bdg_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0_0000_0000_0001,
    S_CLEAR   = 13'b0_0000_0000_0010,
    S_RD_ONLY = 13'b0_0000_0000_0100,
    S_CAP_RD  = 13'b0_0000_0000_1000,
    S_RD_C    = 13'b0_0000_0001_0000,
    S_RD_UP   = 13'b0_0000_0010_0000,
    S_RD_DN   = 13'b0_0000_0100_0000,
    S_RD_LF   = 13'b0_0000_1000_0000,
    S_RD_RT   = 13'b0_0001_0000_0000,
    S_SUM     = 13'b0_0010_0000_0000,
    S_WR_DEP  = 13'b0_0100_0000_0000,
    S_WR_SET  = 13'b0_1000_0000_0000,
    S_DONE    = 13'b1_0000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   rsp_free;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // Output transfer flag
  always_ff @(posedge clk) begin
    if (rst)                                 rsp_valid <= 1'b0;
    else if ((state == S_DONE) && rsp_free)  rsp_valid <= 1'b1;
    else if (!rsp_stall)                     rsp_valid <= 1'b0;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.addr_sel  = ADDR_CENTER;
    cmd.wdata_sel = WSEL_ZERO;
    cmd.nbr_sel   = NBR_UP;
    cmd.res_sel   = RES_HOLD;
    unique case (state)
      S_IDLE: begin
        cmd.load_req = accept;
        if (accept) begin
          priority if (status.req_deposit) state_next = S_RD_C;
          else if (status.req_write)       state_next = S_WR_SET;
          else                             state_next = S_RD_ONLY;
        end
      end
      S_CLEAR: begin
        cmd.mem_we    = 1'b1;
        cmd.addr_sel  = ADDR_CLEAR;
        cmd.wdata_sel = WSEL_ZERO;
        cmd.clr_step  = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_RD_ONLY: begin
        cmd.mem_rd = 1'b1;
        state_next = S_CAP_RD;
      end
      S_CAP_RD: begin
        cmd.res_sel = RES_RDATA;
        state_next  = S_DONE;
      end
      S_RD_C: begin
        cmd.mem_rd  = 1'b1;
        cmd.calc_su = 1'b1;
        state_next  = S_RD_UP;
      end
      S_RD_UP: begin
        cmd.mem_rd      = 1'b1;
        cmd.addr_sel    = ADDR_UP;
        cmd.cap_center  = 1'b1;
        cmd.calc_factor = 1'b1;
        state_next      = S_RD_DN;
      end
      S_RD_DN: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_DN;
        cmd.cap_nbr  = 1'b1;
        cmd.nbr_sel  = NBR_UP;
        cmd.mul_lo   = 1'b1;
        state_next   = S_RD_LF;
      end
      S_RD_LF: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_LF;
        cmd.cap_nbr  = 1'b1;
        cmd.nbr_sel  = NBR_DN;
        cmd.mul_hi   = 1'b1;
        state_next   = S_RD_RT;
      end
      S_RD_RT: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_RT;
        cmd.cap_nbr  = 1'b1;
        cmd.nbr_sel  = NBR_LF;
        state_next   = S_SUM;
      end
      S_SUM: begin
        cmd.cap_nbr  = 1'b1;
        cmd.nbr_sel  = NBR_RT;
        cmd.calc_sum = 1'b1;
        state_next   = S_WR_DEP;
      end
      S_WR_DEP: begin
        cmd.mem_we    = 1'b1;
        cmd.wdata_sel = WSEL_DEP;
        cmd.res_sel   = RES_DEP;
        state_next    = S_DONE;
      end
      S_WR_SET: begin
        cmd.mem_we    = 1'b1;
        cmd.wdata_sel = WSEL_VALUE;
        cmd.res_sel   = RES_WVAL;
        state_next    = S_DONE;
      end
      S_DONE: begin
        cmd.load_rsp = rsp_free;
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- sv/ballistic_deposition_grid.sv -----
// ----------------------------------------------------------------------------
// ballistic_deposition_grid
// Height grid with particle deposit, cell write and cell read items.
// ----------------------------------------------------------------------------
// After reset the block zeroes its 65536-entry height memory in a clearing
// pass and holds req_stall high until it is done; configuration writes are
// taken at any time. Every item then yields exactly one response. The grid
// sits in one single-port memory, so an item's cost is its memory accesses
// in sequence: a deposit reads the cell and its four neighbors and writes
// the cell back, a write writes the cell once and a read reads it once. A
// new item is accepted only after the last one is through. A finished
// response waits in an output register, and the next item is accepted while
// it waits.
module ballistic_deposition_grid (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  bdg_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output bdg_pkg::rsp_t             rsp,
  input  logic                      cfg_we,
  input  bdg_pkg::cfg_idx_t         cfg_index,
  input  logic [bdg_pkg::CFG_W-1:0] cfg_data
);
  import bdg_pkg::*;

  bdg_cmd_t    cmd;
  bdg_status_t status;

  // Sequencer
  bdg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Memory and arithmetic
  bdg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ballistic_deposition_grid. A directed table walks
// the border cells, saturation, writes, reads and the reserved opcode. It is
// followed by phases of random traffic, each with its own particle step and
// spread setting. The bench keeps its own copy of the height grid, predicts
// each cell result and compares it with the response stream in order.
// ----------------------------------------------------------------------------
module tb;
  import bdg_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int         N_DIR       = 20;
  localparam int         N_PHASE     = 6;
  localparam int         PHASE_ITEMS = 190;
  localparam int         HOLD_CYCLES = 400;
  localparam int         CYCLE_LIMIT = 600000;

  // Directed row: item, whether the result is given here, and that result
  typedef struct packed {
    req_t it;
    logic typed;
    rsp_t want;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{'{OP_READ,     8'd0,   8'd0,   16'h0000, 32'h0000_0000}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{OP_READ,     8'd255, 8'd255, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{OP_DEPOSIT,  8'd0,   8'd0,   16'h0000, 32'h0000_0000}, 1'b1, '{32'h0001_0000, 1'b0}},
    '{'{OP_DEPOSIT,  8'd0,   8'd1,   16'hFFFF, 32'h0000_0000}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{OP_WRITE,    8'd255, 8'd255, 16'h0000, 32'h7FFF_FFF0}, 1'b1, '{32'h7FFF_FFF0, 1'b0}},
    '{'{OP_DEPOSIT,  8'd255, 8'd255, 16'hFFFF, 32'h0000_0000}, 1'b1, '{32'h7FFF_FFFF, 1'b1}},
    '{'{OP_RESERVED, 8'd255, 8'd255, 16'h0000, 32'hFFFF_FFFF}, 1'b1, '{32'h7FFF_FFFF, 1'b0}},
    '{'{OP_WRITE,    8'd255, 8'd0,   16'h0000, 32'h8000_0000}, 1'b1, '{32'h8000_0000, 1'b0}},
    '{'{OP_DEPOSIT,  8'd255, 8'd0,   16'h8000, 32'h0000_0000}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{OP_WRITE,    8'd0,   8'd255, 16'h0000, 32'h7FFF_FFFF}, 1'b1, '{32'h7FFF_FFFF, 1'b0}},
    '{'{OP_DEPOSIT,  8'd0,   8'd255, 16'hFFFF, 32'h0000_0000}, 1'b1, '{32'h7FFF_FFFF, 1'b1}},
    '{'{OP_DEPOSIT,  8'd1,   8'd255, 16'h1234, 32'h0000_0000}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{OP_WRITE,    8'd128, 8'd128, 16'h0000, 32'hFFFF_FFFF}, 1'b1, '{32'hFFFF_FFFF, 1'b0}},
    '{'{OP_READ,     8'd128, 8'd128, 16'hFFFF, 32'h0000_0000}, 1'b1, '{32'hFFFF_FFFF, 1'b0}},
    '{'{OP_WRITE,    8'd128, 8'd127, 16'h0000, 32'h8000_0000}, 1'b1, '{32'h8000_0000, 1'b0}},
    '{'{OP_DEPOSIT,  8'd128, 8'd127, 16'h8000, 32'h0000_0000}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{OP_WRITE,    8'd0,   8'd128, 16'h0000, 32'h5555_5555}, 1'b1, '{32'h5555_5555, 1'b0}},
    '{'{OP_READ,     8'd0,   8'd128, 16'h5555, 32'hAAAA_AAAA}, 1'b1, '{32'h5555_5555, 1'b0}},
    '{'{OP_DEPOSIT,  8'd255, 8'd128, 16'hFFFF, 32'h0000_0000}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{OP_DEPOSIT,  8'd128, 8'd0,   16'hAAAA, 32'h0000_0000}, 1'b0, '{32'h0000_0000, 1'b0}}
  };

  // Step/spread per random phase; the last two phases draw their own
  localparam logic [25:0] PHASE_STEP   [N_PHASE] =
    '{26'd0, 26'h3FF_FFFF, 26'd1, 26'd65536000, 26'd0, 26'd0};
  localparam logic [25:0] PHASE_SPREAD [N_PHASE] =
    '{26'h3FF_FFFF, 26'd65536, 26'd0, 26'd32768, 26'd0, 26'd0};

  logic  clk = 1'b0;
  logic  rst;
  logic  req_valid;
  logic  req_stall;
  req_t  req;
  logic  rsp_valid;
  logic  rsp_stall;
  rsp_t  rsp;
  logic  cfg_we;
  cfg_idx_t    cfg_index;
  logic [25:0] cfg_data;

  // Bench copy of block state
  int          height_map [GRID_DEPTH];
  logic [25:0] step_cfg   = 26'(STEP_RESET);
  logic [16:0] spread_cfg = 17'(SPREAD_RESET);

  rsp_t cell_exp_q [$];
  rsp_t exp_head;

  int  err_cnt   = 0;
  int  n_deposit = 0;
  int  n_write   = 0;
  int  n_read    = 0;
  int  n_rsp     = 0;
  int  n_sat     = 0;
  int  cycle_cnt = 0;
  bit  idle_en   = 1'b0;
  bit  hold_req  = 1'b0;

  ballistic_deposition_grid dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Update the grid copy for one item and return the cell it leaves behind
  function automatic rsp_t predict_cell(input req_t it);
    int unsigned       r, c, k;
    longint            cur, sum, up, dn, lf, rt;
    longint unsigned   s, factor, size;
    rsp_t              res;
    r = it.row;
    c = it.col;
    if (r > GRID_ROWS - 1) r = GRID_ROWS - 1;
    if (c > GRID_COLS - 1) c = GRID_COLS - 1;
    k = r * GRID_COLS + c;
    res.saturated = 1'b0;
    if (it.opcode == OP_DEPOSIT) begin
      // spread saturates at full; factor is Q1.32
      s = spread_cfg;
      if (s > ONE_Q16) s = ONE_Q16;
      factor = (64'(ONE_Q16) - s) * 64'd65536 + s * 64'(it.random_fraction);
      size   = (64'(step_cfg) * factor) >> 32;
      cur = height_map[k];
      sum = cur + longint'(size);
      if (sum > 64'sd2147483647) begin
        sum = 64'sd2147483647;
        res.saturated = 1'b1;
      end
      // missing neighbors at the border fall back to the cell itself
      up = (r > 0)             ? height_map[k - GRID_COLS] : cur;
      dn = (r < GRID_ROWS - 1) ? height_map[k + GRID_COLS] : cur;
      lf = (c > 0)             ? height_map[k - 1]         : cur;
      rt = (c < GRID_COLS - 1) ? height_map[k + 1]         : cur;
      if (up > sum) sum = up;
      if (dn > sum) sum = dn;
      if (lf > sum) sum = lf;
      if (rt > sum) sum = rt;
      height_map[k] = int'(sum);
    end else if (it.opcode == OP_WRITE) begin
      height_map[k] = it.write_value;
    end
    res.cell_value = height_map[k];
    return res;
  endfunction

  // Random item, mostly inside an 8x8 window so neighbors interact
  function automatic req_t rand_item(input logic [7:0] wr, input logic [7:0] wc);
    req_t it;
    int   sel;
    sel = $urandom_range(0, 99);
    if (sel < 60)      it.opcode = OP_DEPOSIT;
    else if (sel < 78) it.opcode = OP_WRITE;
    else if (sel < 95) it.opcode = OP_READ;
    else               it.opcode = OP_RESERVED;
    if ($urandom_range(0, 4) != 0) begin
      it.row = wr + 8'($urandom_range(0, 7));
      it.col = wc + 8'($urandom_range(0, 7));
    end else begin
      it.row = 8'($urandom);
      it.col = 8'($urandom);
    end
    it.random_fraction = 16'($urandom);
    case ($urandom_range(0, 2))
      0:       it.write_value = 32'h7FFF_0000 | 32'($urandom_range(0, 65535));
      1:       it.write_value = 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
      default: it.write_value = $urandom;
    endcase
    return it;
  endfunction

  // One request transfer; the expectation is queued at the accepting edge
  task automatic send_item(input req_t it, input logic typed, input rsp_t want);
    rsp_t pred;
    @(negedge clk);
    req_valid = 1'b1;
    req       = it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = predict_cell(it);
    cell_exp_q.push_back(typed ? want : pred);
    if (it.opcode == OP_DEPOSIT)    n_deposit++;
    else if (it.opcode == OP_WRITE) n_write++;
    else                            n_read++;
  endtask

  // Register write; the copy follows at once since the block is idle
  task automatic cfg_write(input cfg_idx_t idx, input logic [25:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    if (idx == CFG_STEP_HEIGHT) step_cfg   = val;
    else                        spread_cfg = val[16:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_valid = 1'b0;
    while (cell_exp_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    int n;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        rsp_stall = 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        rsp_stall = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        rsp_stall = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        rsp_stall = 1'b0;
      end else begin
        rsp_stall = 1'b0;
      end
    end
  end

  // Response checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (cell_exp_q.size() == 0) begin
        $error("unexpected response: cell_value %h saturated %b",
               rsp.cell_value, rsp.saturated);
        err_cnt++;
      end else begin
        exp_head = cell_exp_q.pop_front();
        n_rsp++;
        if (rsp.saturated) n_sat++;
        if (rsp.cell_value !== exp_head.cell_value) begin
          $error("cell_value: expected %h, actual %h",
                 exp_head.cell_value, rsp.cell_value);
          err_cnt++;
        end
        if (rsp.saturated !== exp_head.saturated) begin
          $error("saturated: expected %b, actual %b",
                 exp_head.saturated, rsp.saturated);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[ballistic_deposition_grid] ERROR");
    $finish;
  end

  // Stimulus
  initial begin
    int          d, ph, i;
    logic [7:0]  win_r, win_c;
    logic [25:0] step_v, spread_v;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_STEP_HEIGHT;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table at reset settings; first item waits out the clear pass
    for (d = 0; d < N_DIR; d++)
      send_item(DIR_TAB[d].it, DIR_TAB[d].typed, DIR_TAB[d].want);

    // Random phases, one register setting each
    for (ph = 0; ph < N_PHASE; ph++) begin
      drain_results();
      repeat (4) @(negedge clk);
      step_v   = (ph < 4) ? PHASE_STEP[ph]   : 26'($urandom_range(1, 26'h3FF_FFFF));
      spread_v = (ph < 4) ? PHASE_SPREAD[ph] : 26'($urandom_range(0, 131071));
      cfg_write(CFG_STEP_HEIGHT, step_v);
      cfg_write(CFG_HEIGHT_SPREAD, spread_v);
      win_r = 8'd0;
      win_c = 8'd0;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // last phase runs with no idling at all
        idle_en = (ph < N_PHASE - 1) && ((i % 64) < 48);
        if (i % 32 == 0) begin
          case ($urandom_range(0, 2))
            0:       win_r = 8'd0;
            1:       win_r = 8'd248;
            default: win_r = 8'($urandom_range(0, 248));
          endcase
          case ($urandom_range(0, 2))
            0:       win_c = 8'd0;
            1:       win_c = 8'd248;
            default: win_c = 8'($urandom_range(0, 248));
          endcase
        end
        if (ph == 1 && i == 40) hold_req = 1'b1;
        if (ph == 3 && i == 100) drain_results();
        send_item(rand_item(win_r, win_c), 1'b0, '0);
        // sender keeps pushing through the long receiver hold
        if (idle_en && !(ph == 1 && i >= 40 && i < 60) && $urandom_range(0, 5) == 0) begin
          @(negedge clk);
          req_valid = 1'b0;
          repeat ($urandom_range(0, 6)) @(negedge clk);
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d deposits, %0d writes, %0d reads over %0d settings",
             n_deposit, n_write, n_read, N_PHASE + 1);
    $display("checked %0d responses, %0d saturated, %0d errors",
             n_rsp, n_sat, err_cnt);
    if (err_cnt == 0) begin
      $display("[ballistic_deposition_grid] OK");
    end else begin
      $display("[ballistic_deposition_grid] ERROR");
    end
    $finish;
  end

endmodule
